FILE: hdl/pcs_pkg.sv
// constants, types and helpers for the powerline command sender
// no dependencies; imported by powerline_command_sender_core
`default_nettype none

package pcs_pkg;

    // item kinds
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // command characters
    localparam logic [7:0] CHAR_ON     = 8'h21;  // '!'
    localparam logic [7:0] CHAR_OFF    = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOW_E  = 8'h65;  // 'e'
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;  // 'f'

    // frame layout
    localparam int FRAME_LEN = 20;
    localparam int FIELD_W   = 5;
    localparam int POS_W     = $clog2(FRAME_LEN);

    localparam logic [FIELD_W-1:0] ONOFF_ON   = 5'b00001;
    localparam logic [FIELD_W-1:0] ONOFF_OFF  = 5'b00000;
    localparam logic [FIELD_W-1:0] FUNC_ZERO  = 5'b00010;
    localparam logic [FIELD_W-1:0] FUNC_F     = 5'b10001;
    localparam logic [FIELD_W-1:0] TAIL_BITS  = 5'b10011;
    localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(FRAME_LEN - 1);

    // burst counts
    localparam logic [1:0] BURSTS_NONE     = 2'd0;
    localparam logic [1:0] BURSTS_PREAMBLE = 2'd2;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] code;
    } field_code_t;

    // unit character: '0'..'9' -> 2..11, 'a'..'e' -> 12..16
    function automatic field_code_t unit_code(input logic [7:0] c);
        field_code_t r;
        r.ok   = 1'b0;
        r.code = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            r.ok   = 1'b1;
            r.code = {1'b0, c[3:0]} + 5'd2;
        end
        else if (c >= CHAR_LOW_A && c <= CHAR_LOW_E)
        begin
            r.ok   = 1'b1;
            r.code = {2'b00, c[2:0]} + 5'd11;
        end
        return r;
    endfunction

    // on/off character
    function automatic field_code_t onoff_code(input logic [7:0] c);
        field_code_t r;
        r.ok   = 1'b1;
        r.code = ONOFF_OFF;
        if (c == CHAR_ON)
            r.code = ONOFF_ON;
        else if (c != CHAR_OFF)
            r.ok = 1'b0;
        return r;
    endfunction

    // function character
    function automatic field_code_t func_code(input logic [7:0] c);
        field_code_t r;
        r.ok   = 1'b1;
        r.code = FUNC_ZERO;
        if (c == CHAR_LOW_F)
            r.code = FUNC_F;
        else if (c != CHAR_ZERO)
            r.ok = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/powerline_command_sender_core.sv
// powerline command sender: frame builder and zero-crossing burst sequencer
// depends on pcs_pkg
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, kind, first_char, unit_char, | in
//          | function_char                                    |
//  out     | out_valid, out_ready, bursts, command_accepted,  | out
//          | frame_done, busy_res                             |
//
// one word accepted per clock while in_ready is high; its result word is written to
// the result register in the cycle after the word is accepted.
// in_ready is high whenever the result register is empty or being taken, so
// words stream at one per cycle while out_ready stays high.
// a stalled result holds its register and holds off the next input word.
// rst_n clears the frame state and empties the result register.
`default_nettype none

module powerline_command_sender_core
    import pcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] first_char,
    input  wire logic [7:0] unit_char,
    input  wire logic [7:0] function_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      bursts,
    output logic            command_accepted,
    output logic            frame_done,
    output logic            busy_res
);

    // frame state
    logic [FRAME_LEN-1:0] frame_reg,       frame_next;
    logic [POS_W-1:0]     pos_reg,         pos_next;
    logic                 second_half_reg, second_half_next;
    logic                 sending_reg,     sending_next;
    logic                 preamble_reg,    preamble_next;

    // result register
    logic                 res_valid_reg,   res_valid_next;
    logic [1:0]           bursts_reg,      bursts_next;
    logic                 accepted_reg,    accepted_next;
    logic                 done_reg,        done_next;
    logic                 busy_reg;

    logic                 in_fire;
    field_code_t          onoff_f, unit_f, func_f;
    logic                 cmd_ok;
    logic                 cur_bit;

    // handshake
    assign in_ready = !res_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // command decode
    assign onoff_f = onoff_code(first_char);
    assign unit_f  = unit_code(unit_char);
    assign func_f  = func_code(function_char);
    assign cmd_ok  = onoff_f.ok && unit_f.ok && func_f.ok;
    assign cur_bit = frame_reg[FRAME_LEN-1];

    // next state and result
    always_comb
    begin
        frame_next       = frame_reg;
        pos_next         = pos_reg;
        second_half_next = second_half_reg;
        sending_next     = sending_reg;
        preamble_next    = preamble_reg;
        bursts_next      = BURSTS_NONE;
        accepted_next    = 1'b0;
        done_next        = 1'b0;

        if (kind == KIND_COMMAND)
        begin
            if (cmd_ok && !sending_reg)
            begin
                frame_next       = {onoff_f.code, unit_f.code, func_f.code, TAIL_BITS};
                pos_next         = '0;
                second_half_next = 1'b0;
                preamble_next    = 1'b0;
                sending_next     = 1'b1;
                accepted_next    = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            if (!preamble_reg)
            begin
                bursts_next   = BURSTS_PREAMBLE;
                preamble_next = 1'b1;
            end
            else if (!second_half_reg)
            begin
                bursts_next      = {1'b0, cur_bit};
                second_half_next = 1'b1;
            end
            else
            begin
                // second half: send the complement, then move to the next bit
                bursts_next      = {1'b0, !cur_bit};
                second_half_next = 1'b0;
                frame_next       = {frame_reg[FRAME_LEN-2:0], 1'b0};
                if (pos_reg == LAST_POS)
                begin
                    pos_next      = '0;
                    sending_next  = 1'b0;
                    preamble_next = 1'b0;
                    done_next     = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // result valid tracking
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (in_fire)
            res_valid_next = 1'b1;
        else if (out_ready)
            res_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg       <= '0;
            pos_reg         <= '0;
            second_half_reg <= 1'b0;
            sending_reg     <= 1'b0;
            preamble_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (in_fire)
            begin
                frame_reg       <= frame_next;
                pos_reg         <= pos_next;
                second_half_reg <= second_half_next;
                sending_reg     <= sending_next;
                preamble_reg    <= preamble_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            bursts_reg   <= bursts_next;
            accepted_reg <= accepted_next;
            done_reg     <= done_next;
            busy_reg     <= sending_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign bursts           = bursts_reg;
    assign command_accepted = accepted_reg;
    assign frame_done       = done_reg;
    assign busy_res         = busy_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && done_reg) |-> !busy_reg)
        else $error("frame_done reported while still busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && accepted_reg) |-> (busy_reg && bursts_reg == BURSTS_NONE))
        else $error("accepted command not busy or with bursts");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (pos_reg == '0 && !second_half_reg && !preamble_reg))
        else $error("idle with stale bit position");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("bit position past frame end");

    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && done_next) |-> (pos_reg == LAST_POS && second_half_reg))
        else $error("frame ended before last bit");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// testbench for powerline_command_sender_core: directed table, then random command/tick words
// scores every result word against a typed table result or a built-in frame and burst predictor
// depends on pcs_pkg and the core rtl
`default_nettype none

module tb_top;
    import pcs_pkg::*;

    localparam int RAND_PER_PHASE = 330;
    localparam int NUM_PHASES     = 5;
    localparam int NUM_DIRECTED   = 22;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] first_char;
        logic [7:0] unit_char;
        logic [7:0] function_char;
    } word_t;

    typedef struct packed {
        logic [1:0] bursts;
        logic       accepted;
        logic       done;
        logic       busy;
    } result_t;

    typedef struct packed {
        word_t   w;
        logic    typed;
        result_t res;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       kind;
    logic [7:0] first_char;
    logic [7:0] unit_char;
    logic [7:0] function_char;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] bursts;
    logic       command_accepted;
    logic       frame_done;
    logic       busy_res;

    // predictor copy of the frame state
    logic [FRAME_LEN-1:0] frm_bits;
    logic [4:0]           frm_pos;
    logic                 frm_second;
    logic                 frm_sending;
    logic                 frm_preamble;

    result_t expected_q[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct;
    int      stall_pct;

    // directed words; typed results only where obvious
    row_t dir_rows [0:NUM_DIRECTED-1] = '{
        // idle ticks right after reset
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_TICK, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        // unknown characters are dropped while idle
        '{'{KIND_COMMAND, 8'h00, 8'h00, 8'h00}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_ON, 8'h2F, CHAR_ZERO}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_ON, 8'h3A, CHAR_ZERO}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_OFF, 8'h60, CHAR_LOW_F}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_OFF, CHAR_LOW_F, CHAR_LOW_F}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, 8'h20, CHAR_ZERO, CHAR_ZERO}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_ON, CHAR_ZERO, 8'h31}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        '{'{KIND_COMMAND, CHAR_ON, CHAR_LOW_E, 8'h65}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b0}},
        // good command starts a frame
        '{'{KIND_COMMAND, CHAR_ON, CHAR_ZERO, CHAR_ZERO}, 1'b1, '{2'd0, 1'b1, 1'b0, 1'b1}},
        // command while busy is dropped
        '{'{KIND_COMMAND, CHAR_OFF, CHAR_LOW_E, CHAR_LOW_F}, 1'b1, '{2'd0, 1'b0, 1'b0, 1'b1}},
        // preamble tick
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b1, '{BURSTS_PREAMBLE, 1'b0, 1'b0, 1'b1}},
        // first frame bits
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        '{'{KIND_TICK, 8'h00, 8'h00, 8'h00}, 1'b0, '0}
    };

    powerline_command_sender_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .first_char       (first_char),
        .unit_char        (unit_char),
        .function_char    (function_char),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .bursts           (bursts),
        .command_accepted (command_accepted),
        .frame_done       (frame_done),
        .busy_res         (busy_res)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // frame builder and burst sequencer, one word at a time
    task automatic predict_word(input word_t w, output result_t r);
        logic                ok;
        logic [FIELD_W-1:0]  onoff;
        logic [FIELD_W-1:0]  unit;
        logic [FIELD_W-1:0]  func;
        logic                bit_v;
        r     = '0;
        ok    = 1'b1;
        onoff = ONOFF_OFF;
        unit  = '0;
        func  = FUNC_ZERO;
        if (w.kind == KIND_COMMAND)
        begin
            if (w.first_char == CHAR_ON)
                onoff = ONOFF_ON;
            else if (w.first_char != CHAR_OFF)
                ok = 1'b0;
            if (w.unit_char >= CHAR_ZERO && w.unit_char <= CHAR_NINE)
                unit = FIELD_W'(w.unit_char - CHAR_ZERO) + 5'd2;
            else if (w.unit_char >= CHAR_LOW_A && w.unit_char <= CHAR_LOW_E)
                unit = FIELD_W'(w.unit_char - CHAR_LOW_A) + 5'd12;
            else
                ok = 1'b0;
            if (w.function_char == CHAR_LOW_F)
                func = FUNC_F;
            else if (w.function_char != CHAR_ZERO)
                ok = 1'b0;
            if (ok && !frm_sending)
            begin
                frm_bits     = {onoff, unit, func, TAIL_BITS};
                frm_pos      = '0;
                frm_second   = 1'b0;
                frm_preamble = 1'b0;
                frm_sending  = 1'b1;
                r.accepted   = 1'b1;
            end
        end
        else if (frm_sending)
        begin
            if (!frm_preamble)
            begin
                r.bursts     = BURSTS_PREAMBLE;
                frm_preamble = 1'b1;
            end
            else
            begin
                bit_v = frm_bits[FRAME_LEN - 1 - int'(frm_pos)];
                if (!frm_second)
                begin
                    // burst in the first half for a one
                    r.bursts   = {1'b0, bit_v};
                    frm_second = 1'b1;
                end
                else
                begin
                    // burst in the second half for a zero
                    r.bursts   = {1'b0, ~bit_v};
                    frm_second = 1'b0;
                    if (int'(frm_pos) == FRAME_LEN - 1)
                    begin
                        frm_pos      = '0;
                        frm_sending  = 1'b0;
                        frm_preamble = 1'b0;
                        r.done       = 1'b1;
                    end
                    else
                        frm_pos = frm_pos + 5'd1;
                end
            end
        end
        r.busy = frm_sending;
    endtask

    function automatic word_t good_command();
        word_t w;
        w.kind          = KIND_COMMAND;
        w.first_char    = ($urandom_range(1) != 0) ? CHAR_ON : CHAR_OFF;
        w.unit_char     = ($urandom_range(1) != 0) ? CHAR_ZERO + 8'($urandom_range(9))
                                                   : CHAR_LOW_A + 8'($urandom_range(4));
        w.function_char = ($urandom_range(1) != 0) ? CHAR_LOW_F : CHAR_ZERO;
        return w;
    endfunction

    // mostly ticks while a frame runs, mostly good commands while idle
    function automatic word_t pick_word();
        word_t w;
        int    roll;
        w.kind          = KIND_COMMAND;
        w.first_char    = 8'($urandom);
        w.unit_char     = 8'($urandom);
        w.function_char = 8'($urandom);
        roll = $urandom_range(99);
        if (frm_sending)
        begin
            if (roll < 85)
                w.kind = KIND_TICK;
            else if (roll < 95)
                w = good_command();
        end
        else
        begin
            if (roll < 55)
                w = good_command();
            else if (roll < 70)
            begin
                // one broken character in an otherwise good command
                w = good_command();
                case ($urandom_range(2))
                    0: w.first_char = 8'($urandom);
                    1: w.unit_char = 8'($urandom);
                    default: w.function_char = 8'($urandom);
                endcase
            end
            else if (roll < 85)
                w.kind = KIND_TICK;
        end
        return w;
    endfunction

    // present one word, hold it until taken, then queue its result
    task automatic send_word(input word_t w, input logic typed, input result_t typed_res);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= w.kind;
        first_char    <= w.first_char;
        unit_char     <= w.unit_char;
        function_char <= w.function_char;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(w, r);
        expected_q.push_back(typed ? typed_res : r);
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // result scoreboard
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word bursts=%0d acc=%0b done=%0b busy=%0b",
                         $time, bursts, command_accepted, frame_done, busy_res);
                error_count++;
            end
            else
            begin
                result_t exp_r;
                exp_r = expected_q.pop_front();
                if (exp_r.bursts !== bursts || exp_r.accepted !== command_accepted ||
                    exp_r.done !== frame_done || exp_r.busy !== busy_res)
                begin
                    $display("%0t: mismatch expected bursts=%0d acc=%0b done=%0b busy=%0b",
                             $time, exp_r.bursts, exp_r.accepted, exp_r.done, exp_r.busy);
                    $display("%0t:          actual   bursts=%0d acc=%0b done=%0b busy=%0b",
                             $time, bursts, command_accepted, frame_done, busy_res);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        word_t w;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = KIND_COMMAND;
        first_char    = 8'h00;
        unit_char     = 8'h00;
        function_char = 8'h00;
        send_idle_pct = 0;
        stall_pct     = 0;
        frm_bits      = '0;
        frm_pos       = '0;
        frm_second    = 1'b0;
        frm_sending   = 1'b0;
        frm_preamble  = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        // random phases, each drained before the next
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                3: begin send_idle_pct = 35; stall_pct = 35; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                w = pick_word();
                send_word(w, 1'b0, '0);
            end
            in_valid <= 1'b0;
            while (expected_q.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
